@@ rtl/grid_line_of_sight_unit_defines.svh @@
// Assertion macros shared by the line-of-sight RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH

// property must hold at every clock edge out of reset
`define GLOS_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen out of reset
`define GLOS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ rtl/glos_pkg.sv @@
// Shared constants and types for the grid line-of-sight unit.
// No dependencies.
`default_nettype none

package glos_pkg;

	localparam int MAP_SIDE = 64;
	localparam int IDX_W    = $clog2(MAP_SIDE);
	localparam int CFG_W    = 7;
	localparam int CRD_W    = 6;
	localparam int DLT_W    = 7;
	localparam int POS_W    = 8;
	localparam int REM_W    = 9;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MAP_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_MAP_HEIGHT = 1'b1;

	typedef struct packed {
		logic             is_query;
		logic             zero;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic             blk;
		logic             neg_x;
		logic             neg_y;
		logic [DLT_W-1:0] ax;
		logic [DLT_W-1:0] ay;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

endpackage

`default_nettype wire

@@ rtl/glos_if.sv @@
// Request and result channel interfaces of the line-of-sight unit.
// No dependencies.
`default_nettype none

interface glos_req_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic [5:0]        cell_x;
	logic [5:0]        cell_y;
	logic              cell_blocked;
	logic [5:0]        origin_x;
	logic [5:0]        origin_y;
	logic signed [6:0] delta_x;
	logic signed [6:0] delta_y;

	modport source (output valid, func, cell_x, cell_y, cell_blocked, origin_x, origin_y,
		delta_x, delta_y, input ready);
	modport sink (input valid, func, cell_x, cell_y, cell_blocked, origin_x, origin_y,
		delta_x, delta_y, output ready);
endinterface

interface glos_res_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

@@ rtl/glos_ram.sv @@
// Generic simple dual-port RAM, registered read, no reset on contents.
// No dependencies.
`default_nettype none

module glos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

@@ rtl/glos_front.sv @@
// Front end: accepts requests, classifies them and queues them for the walker.
// Uses glos_pkg and glos_req_if.
`default_nettype none

module glos_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	glos_req_if.sink              req,
	input  wire logic             pop,
	output glos_pkg::q_head_t     head
);

	glos_pkg::op_t                   op_new;
	logic [glos_pkg::DLT_W-1:0]      dxu;
	logic [glos_pkg::DLT_W-1:0]      dyu;
	logic                            in_store;
	logic                            push;
	glos_pkg::op_t                   slot_q [glos_pkg::QDEPTH];
	logic [glos_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [glos_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [glos_pkg::QCNT_W-1:0]     cnt_q;

	always_comb begin
		dxu = req.delta_x;
		dyu = req.delta_y;
		in_store = (int'(req.cell_x) < glos_pkg::MAP_SIDE) &&
			(int'(req.cell_y) < glos_pkg::MAP_SIDE);
		op_new.is_query = (req.func == glos_pkg::FUNC_QUERY);
		op_new.x        = op_new.is_query ? req.origin_x : req.cell_x;
		op_new.y        = op_new.is_query ? req.origin_y : req.cell_y;
		op_new.blk      = req.cell_blocked;
		op_new.neg_x    = dxu[glos_pkg::DLT_W-1];
		op_new.neg_y    = dyu[glos_pkg::DLT_W-1];
		op_new.ax       = dxu[glos_pkg::DLT_W-1] ? (~dxu + glos_pkg::DLT_W'(1)) : dxu;
		op_new.ay       = dyu[glos_pkg::DLT_W-1] ? (~dyu + glos_pkg::DLT_W'(1)) : dyu;
		op_new.zero     = (dxu == '0) && (dyu == '0);
	end

	// writes outside the store are dropped here
	assign req.ready = (cnt_q != glos_pkg::QCNT_W'(glos_pkg::QDEPTH));
	assign push      = req.valid && req.ready && (op_new.is_query || in_store);

	assign head.valid = (cnt_q != '0);
	assign head.op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + glos_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + glos_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + glos_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - glos_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_new;
		end
	end

endmodule

`default_nettype wire

@@ rtl/glos_walk.sv @@
// Back end: map store, cell writes and the line walker with its result register.
// Uses glos_pkg, glos_res_if, glos_ram and the assertion macro header.
`default_nettype none
`include "grid_line_of_sight_unit_defines.svh"

module glos_walk (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire glos_pkg::q_head_t          head,
	output logic                            pop,
	input  wire logic [glos_pkg::CFG_W-1:0] map_width,
	input  wire logic [glos_pkg::CFG_W-1:0] map_height,
	glos_res_if.source                      res
);

	localparam int POS_W = glos_pkg::POS_W;
	localparam int REM_W = glos_pkg::REM_W;
	localparam int IDX_W = glos_pkg::IDX_W;
	localparam int DLT_W = glos_pkg::DLT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_WALK} state_t;

	state_t                      st_q;
	glos_pkg::op_t               op_q;
	logic signed [POS_W-1:0]     x_q;
	logic signed [POS_W-1:0]     y_q;
	logic signed [REM_W-1:0]     rem_q;
	logic [DLT_W-1:0]            cnt_q;
	logic                        gen_done_q;

	logic                        vld_s1;
	logic                        last_s1;
	logic signed [POS_W-1:0]     x_s1;
	logic signed [POS_W-1:0]     y_s1;

	logic                        vld_s2;
	logic                        last_s2;
	logic                        oob_s2;
	logic                        rv_s2;
	logic [IDX_W-1:0]            col_s2;

	logic [glos_pkg::MAP_SIDE-1:0] row_vld_q;
	logic                        res_valid_q;
	logic                        res_vis_q;

	logic                        start_ok;
	logic                        gen_act;
	logic                        vertical;
	logic                        ystep;
	logic signed [REM_W:0]       rem_w;
	logic signed [REM_W:0]       ax_s;
	logic signed [REM_W:0]       ax2;
	logic signed [REM_W:0]       ay2;
	logic signed [REM_W:0]       rem_dn;
	logic signed [REM_W:0]       rem_up;
	logic signed [REM_W:0]       nrem;
	logic signed [POS_W-1:0]     x_nx;
	logic signed [POS_W-1:0]     y_nx;
	logic signed [POS_W-1:0]     gen_x;
	logic signed [POS_W-1:0]     gen_y;
	logic [DLT_W-1:0]            cnt_inc;
	logic [DLT_W-1:0]            ncnt;
	logic                        gen_last;
	logic                        oob1;
	logic                        blocked2;
	logic                        finish_walk;
	logic                        res_set;

	logic [IDX_W-1:0]            rd_addr;
	logic [glos_pkg::MAP_SIDE-1:0] rd_data;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [glos_pkg::MAP_SIDE-1:0] wr_data;

	// ---- issue ----
	assign start_ok = head.valid && (!head.op.is_query || !res_valid_q || res.ready);
	assign pop      = (st_q == ST_IDLE) && start_ok;
	assign gen_act  = (st_q == ST_WALK) && !gen_done_q;

	// ---- walk step ----
	always_comb begin
		vertical = (op_q.ax == '0);
		rem_w    = {rem_q[REM_W-1], rem_q};
		ax_s     = $signed({{(REM_W+1-DLT_W){1'b0}}, op_q.ax});
		ax2      = $signed({{(REM_W-DLT_W){1'b0}}, op_q.ax, 1'b0});
		ay2      = $signed({{(REM_W-DLT_W){1'b0}}, op_q.ay, 1'b0});
		rem_dn   = rem_w - ax2;
		rem_up   = rem_w + ay2;
		ystep    = vertical || (rem_w >= ax_s);
		x_nx     = op_q.neg_x ? (x_q - POS_W'(1)) : (x_q + POS_W'(1));
		y_nx     = op_q.neg_y ? (y_q - POS_W'(1)) : (y_q + POS_W'(1));
		cnt_inc  = cnt_q + DLT_W'(1);
		if (vertical) begin
			gen_x    = x_q;
			gen_y    = y_nx;
			nrem     = rem_w;
			ncnt     = cnt_inc;
			gen_last = (cnt_inc == op_q.ay);
		end else if (ystep) begin
			gen_x    = x_q;
			gen_y    = y_nx;
			nrem     = rem_dn;
			ncnt     = cnt_q;
			gen_last = (cnt_q == op_q.ax) && (rem_dn < ax_s);
		end else begin
			gen_x    = x_nx;
			gen_y    = y_q;
			nrem     = rem_up;
			ncnt     = cnt_inc;
			gen_last = (cnt_inc == op_q.ax) && (rem_up < ax_s);
		end
	end

	// ---- cell check ----
	assign oob1 = x_s1[POS_W-1] || y_s1[POS_W-1] ||
		(x_s1[POS_W-2:0] >= map_width) || (y_s1[POS_W-2:0] >= map_height) ||
		(int'(x_s1) >= glos_pkg::MAP_SIDE) || (int'(y_s1) >= glos_pkg::MAP_SIDE);

	assign blocked2    = oob_s2 || (rv_s2 && rd_data[col_s2]);
	assign finish_walk = (st_q == ST_WALK) && vld_s2 && (blocked2 || last_s2);
	assign res_set     = (pop && head.op.is_query && head.op.zero) || finish_walk;

	// ---- map store ----
	assign rd_addr = (st_q == ST_IDLE) ? IDX_W'(head.op.y) : IDX_W'(y_s1);
	assign wr_en   = (st_q == ST_WRITE);
	assign wr_addr = IDX_W'(op_q.y);

	always_comb begin
		wr_data = rv_s2 ? rd_data : '0;
		wr_data[IDX_W'(op_q.x)] = op_q.blk;
	end

	glos_ram #(
		.WIDTH (glos_pkg::MAP_SIDE),
		.DEPTH (glos_pkg::MAP_SIDE)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res.valid   = res_valid_q;
	assign res.visible = res_vis_q;

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			gen_done_q  <= 1'b1;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			row_vld_q   <= '0;
			res_valid_q <= 1'b0;
			res_vis_q   <= 1'b0;
		end else begin
			if (res_set) begin
				res_valid_q <= 1'b1;
				res_vis_q   <= finish_walk ? !blocked2 : 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			vld_s1 <= gen_act && !finish_walk;
			vld_s2 <= vld_s1 && !finish_walk;
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						if (!head.op.is_query) begin
							st_q <= ST_WRITE;
						end else if (!head.op.zero) begin
							st_q       <= ST_WALK;
							gen_done_q <= 1'b0;
						end
					end
				end
				ST_WRITE: begin
					row_vld_q[wr_addr] <= 1'b1;
					st_q               <= ST_IDLE;
				end
				ST_WALK: begin
					if (finish_walk) begin
						st_q       <= ST_IDLE;
						gen_done_q <= 1'b1;
					end else if (gen_act && gen_last) begin
						gen_done_q <= 1'b1;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= head.op;
			x_q   <= $signed({{(POS_W-glos_pkg::CRD_W){1'b0}}, head.op.x});
			y_q   <= $signed({{(POS_W-glos_pkg::CRD_W){1'b0}}, head.op.y});
			rem_q <= '0;
			cnt_q <= '0;
		end else if (gen_act) begin
			x_q   <= gen_x;
			y_q   <= gen_y;
			rem_q <= REM_W'(nrem);
			cnt_q <= ncnt;
		end
		x_s1    <= gen_x;
		y_s1    <= gen_y;
		last_s1 <= gen_last;
		last_s2 <= last_s1;
		oob_s2  <= oob1;
		col_s2  <= IDX_W'(x_s1);
		rv_s2   <= row_vld_q[rd_addr];
	end

	`GLOS_CHK(a_walk_slot_free, st_q == ST_WALK |-> !res_valid_q, "result slot busy during walk")
	`GLOS_CHK(a_s2_in_walk, vld_s2 |-> st_q == ST_WALK, "cell check outside walk")
	`GLOS_CHK(a_write_short, st_q == ST_WRITE |=> st_q == ST_IDLE, "write held over")
	`GLOS_NEVER(a_cnt_range, st_q == ST_WALK && cnt_q > (1 << (DLT_W - 1)), "step count overrun")

endmodule

`default_nettype wire

@@ rtl/grid_line_of_sight_unit.sv @@
// Line-of-sight unit over a one-bit blocked tile map: top level and config registers.
// Uses glos_pkg, glos_if, glos_front and glos_walk.
`default_nettype none

// Keeps a 64 x 64 map of blocked cells and answers line-of-sight queries by
// walking from the viewer to the target one cell per cycle. Requests are
// queued two deep ahead of the walker, so new requests are taken while a query
// runs or a result waits, if the queue has room. A cell write gives no result
// and holds the walker in its write state; a query with zero offset answers
// without a walk; any other query visits at most |dx| + |dy| cells, stopping
// early at the first blocked or out-of-map cell. The single read port of the
// map RAM, one row per cell, sets the walk rate. The map reads as all open
// after reset with no clearing pass (per-row valid bits). The user must write
// map_width and map_height only while the unit is idle; no logic enforces it.
module grid_line_of_sight_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire glos_pkg::cfg_idx_t         cfg_index,
	input  wire logic [glos_pkg::CFG_W-1:0] cfg_data,
	glos_req_if.sink                        req,
	glos_res_if.source                      res
);

	logic [glos_pkg::CFG_W-1:0] map_width_q;
	logic [glos_pkg::CFG_W-1:0] map_height_q;
	glos_pkg::q_head_t          head;
	logic                       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= glos_pkg::CFG_W'(glos_pkg::MAP_SIDE);
			map_height_q <= glos_pkg::CFG_W'(glos_pkg::MAP_SIDE);
		end else if (cfg_we) begin
			case (cfg_index)
				glos_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				glos_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: begin
					map_width_q <= map_width_q;
				end
			endcase
		end
	end

	glos_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	glos_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.res        (res)
	);

endmodule

`default_nettype wire
